// File: hdl/swhc_pkg.sv
// swhc_pkg: shared constants, item and report types for the spill window hit counter
// used by swhc_front, swhc_queue, swhc_back and spill_window_hit_counter
// no dependencies
package swhc_pkg;

   localparam int CHANNELS        = 4;
   localparam int REPORT_CHANNELS = 4;
   localparam int TIME_BITS       = 32;
   localparam int CH_BITS         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int KIND_BITS   = 4;
   localparam int COUNT_BITS  = 32;
   localparam int TICK_BITS   = 40;
   localparam int MARGIN_BITS = 40;

   localparam int REQ_DATA_BITS = 96;
   localparam int REQ_USER_BITS = 5;
   localparam int RSP_USER_BITS = 2;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [KIND_BITS-1:0]  KIND_BEGIN     = 4'd12;
   localparam logic [KIND_BITS-1:0]  KIND_END       = 4'd13;
   localparam logic [COUNT_BITS-1:0] INTERVAL_RESET = 32'd10000000;

   typedef enum logic [RSP_USER_BITS-1:0] {
      RPT_INTERVAL = 2'd0,
      RPT_END      = 2'd1,
      RPT_BEGIN    = 2'd2
   } report_kind_type;

   typedef struct packed {
      logic                  is_chan;
      logic [CH_BITS-1:0]    chan;
      logic                  is_begin;
      logic                  is_end;
      logic                  last;
      logic                  hit;
      logic [COUNT_BITS-1:0] increment;
      logic [TIME_BITS-1:0]  stamp;
      logic [31:0]           offset;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   typedef struct packed {
      logic [REPORT_CHANNELS-1:0][COUNT_BITS-1:0] off_counts;
      logic signed [31:0]                         spill_ticks;
      logic [REPORT_CHANNELS-1:0][COUNT_BITS-1:0] on_counts;
      logic [TICK_BITS-1:0]                       elapsed_ticks;
   } report_type;

   localparam int RSP_DATA_BITS = $bits(report_type);

endpackage

// File: hdl/swhc_front.sv
// swhc_front: accepts requests and classifies the trigger kind
// depends on swhc_pkg
module swhc_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swhc_pkg::REQ_DATA_BITS-1:0] req_tdata,  // hit_increment, event_clock, hit_offset
   input  logic [swhc_pkg::REQ_USER_BITS-1:0] req_tuser,  // trigger_kind, hit_present
   input  logic                               req_tlast,
   input  logic                               queue_full,
   output swhc_pkg::slot_type                 push_slot
);

   logic [swhc_pkg::KIND_BITS-1:0] kind;
   logic                           is_chan;

   assign kind       = req_tuser[swhc_pkg::KIND_BITS-1:0];
   assign is_chan    = (kind != '0) && (32'(kind) <= swhc_pkg::CHANNELS);
   assign req_tready = !queue_full;

   always_comb begin
      push_slot.valid          = req_tvalid && !queue_full;
      push_slot.item.is_chan   = is_chan;
      push_slot.item.chan      = is_chan ? swhc_pkg::CH_BITS'(kind - 4'd1) : '0;
      push_slot.item.is_begin  = (kind == swhc_pkg::KIND_BEGIN);
      push_slot.item.is_end    = (kind == swhc_pkg::KIND_END);
      push_slot.item.last      = req_tlast;
      push_slot.item.hit       = req_tuser[swhc_pkg::KIND_BITS];
      push_slot.item.increment = req_tdata[31:0];
      push_slot.item.stamp     = req_tdata[32 +: swhc_pkg::TIME_BITS];
      push_slot.item.offset    = req_tdata[95:64];
   end

endmodule

// File: hdl/swhc_queue.sv
// swhc_queue: short request queue between front and back
// depends on swhc_pkg
module swhc_queue (
   input  logic               clock,
   input  logic               reset,
   input  swhc_pkg::slot_type push_slot,
   output logic               queue_full,
   output swhc_pkg::slot_type head,
   input  logic               pop
);

   localparam int PB = swhc_pkg::QUEUE_PTR_BITS;

   swhc_pkg::item_type store_ff [swhc_pkg::QUEUE_DEPTH];
   logic [PB-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PB:0]        count_ff, count_in;

   assign queue_full = (count_ff == (PB+1)'(swhc_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_slot.valid ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      case ({push_slot.valid, pop})
         2'b10:   count_in = count_ff + (PB+1)'(1);
         2'b01:   count_in = count_ff - (PB+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_slot.valid) begin
         store_ff[wr_ptr_ff] <= push_slot.item;
      end
   end

endmodule

// File: hdl/swhc_back.sv
// swhc_back: spill state, hit counters, tick accounting and the report register
// depends on swhc_pkg
module swhc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  swhc_pkg::slot_type                 head,
   output logic                               pop,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [31:0]                        csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [swhc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [swhc_pkg::RSP_USER_BITS-1:0] rsp_tuser
);

   localparam int TB = swhc_pkg::TIME_BITS;
   localparam int CH = swhc_pkg::CHANNELS;
   localparam int CB = swhc_pkg::COUNT_BITS;
   localparam int MB = swhc_pkg::MARGIN_BITS;
   localparam int KB = swhc_pkg::TICK_BITS;

   localparam logic signed [TB+1:0] WRAP_LIMIT = (TB+2)'(1) << (TB - 2);
   localparam logic signed [TB+1:0] TIME_SPAN  = (TB+2)'(1) << TB;
   localparam logic [TB-1:0]        WRAP_STEP  = TB'(1) << (TB - 2);
   localparam logic signed [MB:0]   MARGIN_MIN = -((MB+1)'(1) <<< (MB - 1));

   function automatic logic signed [31:0] wrap_diff(input logic [TB-1:0] a,
                                                    input logic [TB-1:0] b);
      logic signed [TB+1:0] d;
      d = $signed({2'b00, a}) - $signed({2'b00, b});
      if (d > WRAP_LIMIT) begin
         d = d - TIME_SPAN;
      end else if (d < -WRAP_LIMIT) begin
         d = d + TIME_SPAN;
      end
      return 32'(d);
   endfunction

   function automatic logic [TB-1:0] clock_delta(input logic [TB-1:0] prev,
                                                 input logic [TB-1:0] c);
      logic [TB-1:0] d;
      d = c - prev;
      if (c < prev && (prev - c) < WRAP_STEP) begin
         d = '0;
      end
      return d;
   endfunction

   swhc_pkg::item_type it;

   logic                  in_spill_ff, in_spill_in;
   logic [TB-1:0]         begin_time_ff, begin_time_in;
   logic [CH-1:0]         first_ff, first_in;
   logic [CH-1:0][CB-1:0] on_ff, on_in, on_add, on_next;
   logic [CH-1:0][CB-1:0] off_ff, off_in, off_add, off_next;
   logic [KB-1:0]         tick_ff, tick_in;
   logic [TB-1:0]         prev_ff, prev_in;
   logic                  seeded_ff, seeded_in;
   logic signed [MB-1:0]  margin_ff, margin_in;
   logic                  margin_loaded_ff, margin_loaded_in;
   logic [31:0]           interval_ff, interval_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   swhc_pkg::report_type  rsp_data_ff, rpt;
   swhc_pkg::report_kind_type rsp_kind_ff, rpt_kind;

   logic                  out_free;
   logic                  emit;
   logic                  first_hit;
   logic signed [31:0]    spill_diff;
   logic signed [MB-1:0]  base;
   logic signed [MB:0]    sub;
   logic signed [MB-1:0]  margin_hit;
   logic [KB:0]           tick_sum;
   logic [KB-1:0]         tick_step;

   assign it         = head.item;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = head.valid && out_free;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   assign first_hit  = it.is_chan && in_spill_ff && first_ff[it.chan];
   assign spill_diff = wrap_diff(it.stamp, begin_time_ff);
   assign base       = margin_loaded_ff ? margin_ff : MB'(spill_diff);
   assign sub        = (MB+1)'(base) - (MB+1)'($signed({1'b0, it.offset}));
   assign margin_hit = (sub < MARGIN_MIN) ? MB'(MARGIN_MIN) : MB'(sub);

   assign tick_sum   = {1'b0, tick_ff} + (KB+1)'(clock_delta(prev_ff, it.stamp));
   assign tick_step  = !seeded_ff ? tick_ff : (tick_sum[KB] ? '1 : tick_sum[KB-1:0]);

   // counter increments from hits and headers
   always_comb begin
      on_add           = '0;
      off_add          = '0;
      margin_in        = margin_ff;
      margin_loaded_in = margin_loaded_ff;
      if (pop && first_hit) begin
         margin_loaded_in = 1'b1;
         margin_in        = base;
         if (it.hit) begin
            margin_in = margin_hit;
            if (margin_hit > 0) begin
               on_add[it.chan] = CB'(1);
            end else begin
               off_add[it.chan] = CB'(1);
            end
         end
      end
      if (pop && it.last) begin
         margin_loaded_in = 1'b0;
         if (it.is_begin) begin
            off_add[0] = it.increment;
         end else if (it.is_end) begin
            on_add[0] = it.increment;
         end else if (it.is_chan) begin
            if (!in_spill_ff) begin
               off_add[it.chan] = it.increment;
            end else if (!first_ff[it.chan]) begin
               on_add[it.chan] = it.increment;
            end
         end
      end
      for (int k = 0; k < CH; k++) begin
         on_next[k]  = on_ff[k] + on_add[k];
         off_next[k] = off_ff[k] + off_add[k];
      end
   end

   // header actions and reports
   always_comb begin
      in_spill_in   = in_spill_ff;
      begin_time_in = begin_time_ff;
      first_in      = first_ff;
      on_in         = on_next;
      off_in        = off_next;
      tick_in       = tick_ff;
      prev_in       = prev_ff;
      seeded_in     = seeded_ff;
      interval_in   = csr_valid ? csr_data : interval_ff;
      emit          = 1'b0;
      rpt_kind      = swhc_pkg::RPT_INTERVAL;
      rpt           = '0;
      if (pop && it.last) begin
         if (it.is_begin) begin
            in_spill_in   = 1'b1;
            begin_time_in = it.stamp;
            first_in      = '1;
            prev_in       = it.stamp;
            seeded_in     = 1'b1;
            emit          = 1'b1;
            rpt_kind      = swhc_pkg::RPT_BEGIN;
         end else if (it.is_end) begin
            in_spill_in       = 1'b0;
            prev_in           = it.stamp;
            seeded_in         = 1'b1;
            emit              = 1'b1;
            rpt_kind          = swhc_pkg::RPT_END;
            rpt.elapsed_ticks = tick_step;
            rpt.spill_ticks   = spill_diff;
            for (int k = 0; k < swhc_pkg::REPORT_CHANNELS && k < CH; k++) begin
               rpt.on_counts[k]  = on_next[k];
               rpt.off_counts[k] = off_next[k];
            end
            on_in   = '0;
            off_in  = '0;
            tick_in = '0;
         end else if (it.is_chan && in_spill_ff) begin
            first_in[it.chan] = 1'b0;
            prev_in           = it.stamp;
            seeded_in         = 1'b1;
            tick_in           = tick_step;
            if (tick_step > KB'(interval_ff)) begin
               emit              = 1'b1;
               rpt.elapsed_ticks = tick_step;
               for (int k = 0; k < swhc_pkg::REPORT_CHANNELS && k < CH; k++) begin
                  rpt.on_counts[k] = on_next[k];
               end
               on_in   = '0;
               tick_in = '0;
            end
         end
      end
      rsp_valid_in = out_free ? (pop && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_spill_ff      <= 1'b0;
         begin_time_ff    <= '0;
         first_ff         <= '0;
         on_ff            <= '0;
         off_ff           <= '0;
         tick_ff          <= '0;
         prev_ff          <= '0;
         seeded_ff        <= 1'b0;
         margin_ff        <= '0;
         margin_loaded_ff <= 1'b0;
         interval_ff      <= swhc_pkg::INTERVAL_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         in_spill_ff      <= in_spill_in;
         begin_time_ff    <= begin_time_in;
         first_ff         <= first_in;
         on_ff            <= on_in;
         off_ff           <= off_in;
         tick_ff          <= tick_in;
         prev_ff          <= prev_in;
         seeded_ff        <= seeded_in;
         margin_ff        <= margin_in;
         margin_loaded_ff <= margin_loaded_in;
         interval_ff      <= interval_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_data_ff <= rpt;
         rsp_kind_ff <= rpt_kind;
      end
   end

   a_begin_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == swhc_pkg::RPT_BEGIN |-> rsp_data_ff == '0)
      else $error("begin of spill report carries nonzero data");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      pop && it.last && it.is_end |=> !in_spill_ff && tick_ff == '0)
      else $error("end of spill left spill mode or ticks set");

   a_interval_in_spill: assert property (@(posedge clock) disable iff (reset)
      pop && emit && rpt_kind == swhc_pkg::RPT_INTERVAL |-> in_spill_ff)
      else $error("interval report outside a spill");

   a_margin_released: assert property (@(posedge clock) disable iff (reset)
      pop && it.last |=> !margin_loaded_ff)
      else $error("margin still loaded after end of event");

endmodule

// File: hdl/spill_window_hit_counter.sv
// spill_window_hit_counter: a request is written into the queue and popped by the counter stage
// (which loads the report register when it emits a report), and the report is held until taken
// throughput one request per cycle while the report output is not stalled; a stalled report
// output fills the four-entry queue before req_tready drops
// reset is synchronous and clears all spill state and counters and sets the interval to
// 10000000 ticks; no clearing pass, requests are taken in the cycle after reset
module spill_window_hit_counter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swhc_pkg::REQ_DATA_BITS-1:0] req_tdata,  // hit_increment, event_clock, hit_offset
   input  logic [swhc_pkg::REQ_USER_BITS-1:0] req_tuser,  // trigger_kind, hit_present
   input  logic                               req_tlast,  // event_last
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // elapsed_ticks, on_count_one..four, spill_ticks, off_count_one..four
   output logic [swhc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [swhc_pkg::RSP_USER_BITS-1:0] rsp_tuser,  // report_kind
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [31:0]                        csr_data    // report_interval
);

   swhc_pkg::slot_type push_slot;
   swhc_pkg::slot_type head;
   logic               queue_full;
   logic               pop;

   swhc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_slot  (push_slot)
   );

   swhc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_slot  (push_slot),
      .queue_full (queue_full),
      .head       (head),
      .pop        (pop)
   );

   swhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
